### rtl/vm_scalar_alu_32_assert.svh
// Assertion macros used by the checker file.
`ifndef VM_SCALAR_ALU_32_ASSERT_SVH
`define VM_SCALAR_ALU_32_ASSERT_SVH

// Checked only while out of reset.
`define VSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define VSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vsa_pkg.sv
// Types and codes of the scalar ALU.
package vsa_pkg;

  localparam int CmdWidth = 3;

  typedef enum logic [CmdWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_MOD = 3'd5
  } op_e;

endpackage

### rtl/vsa_if.sv
// Valid/ready channels of the scalar ALU: instruction in, result out.
interface vsa_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                            valid;
  logic                            ready;
  logic [vsa_pkg::CmdWidth-1:0]    cmd;
  logic [DATA_WIDTH-1:0]           operand_a;
  logic [DATA_WIDTH-1:0]           operand_b;
  logic                            a_is_signed;
  logic                            b_is_signed;
  logic                            types_compatible;

  modport source (
    output valid, cmd, operand_a, operand_b, a_is_signed, b_is_signed, types_compatible,
    input  ready
  );
  modport sink (
    input  valid, cmd, operand_a, operand_b, a_is_signed, b_is_signed, types_compatible,
    output ready
  );
endinterface

interface vsa_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] result_value;
  logic                  crashed;

  modport source (output valid, result_value, crashed, input ready);
  modport sink (input valid, result_value, crashed, output ready);
endinterface

### rtl/vm_scalar_alu_32.sv
// Pipelined scalar ALU: add, sub, neg, mul, signed/unsigned div and mod.
//
//   channel  | dir | word
//   ---------+-----+-------------------------------------------------------
//   in_i     | in  | cmd, operand_a, operand_b, a/b_is_signed, types_compatible
//   out_o    | out | result_value, crashed
//
// One word per cycle while out_o is not stalled; each word passes through the
// input register, DATA_WIDTH restoring divider stages (one quotient bit each)
// and the output register.
// Multiply uses half-width partial products, summed in the first divider stage.
// Reset clears the valid bits only. A stall at out_o holds the whole pipe.
module vm_scalar_alu_32 #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vsa_in_if.sink    in_i,
  vsa_out_if.source out_o
);
  import vsa_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int HW = (DATA_WIDTH + 1) / 2;

  typedef struct packed {
    op_e          op;
    logic         ok;
    logic         na;
    logic         nb;
    logic         bz;
    logic [W-1:0] a;
    logic [W-1:0] res;
    logic [W-1:0] mb;
    logic [W-1:0] dvd;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
  } stage_t;

  stage_t           st_d [W+1];
  stage_t           st_q [W+1];
  logic   [W:0]     v_q;
  logic   [2*HW-1:0] pp_ll_d, pp_ll_q;
  logic   [W-1:0]   pp_lh_d, pp_lh_q;
  logic   [W-1:0]   pp_hl_d, pp_hl_q;
  logic             out_v_q;
  logic   [W-1:0]   res_d, res_q;
  logic             crash_d, crash_q;
  logic             en;

  assign en        = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    logic [W:0]   trial;
    logic [W-1:0] ra;
    logic [W-1:0] rb;
    logic         sa;
    logic         sb;
    ra = in_i.operand_a;
    rb = in_i.operand_b;
    sa = in_i.a_is_signed && ra[W-1];
    sb = in_i.b_is_signed && rb[W-1];
    st_d[0].op  = op_e'(in_i.cmd);
    st_d[0].ok  = in_i.types_compatible;
    st_d[0].na  = sa;
    st_d[0].nb  = sb;
    st_d[0].bz  = (rb == '0);
    st_d[0].a   = ra;
    st_d[0].mb  = sb ? (~rb + W'(1)) : rb;
    st_d[0].dvd = sa ? (~ra + W'(1)) : ra;
    st_d[0].rem = '0;
    st_d[0].quo = '0;
    case (op_e'(in_i.cmd))
      OP_ADD:  st_d[0].res = ra + rb;
      OP_SUB:  st_d[0].res = ra - rb;
      OP_NEG:  st_d[0].res = ~ra + W'(1);
      default: st_d[0].res = '0;
    endcase
    pp_ll_d = ra[HW-1:0] * rb[HW-1:0];
    pp_lh_d = W'(ra[HW-1:0] * rb[W-1:HW]);
    pp_hl_d = W'(ra[W-1:HW] * rb[HW-1:0]);
    for (int k = 1; k <= W; k++) begin
      st_d[k] = st_q[k-1];
      trial   = {st_q[k-1].rem, st_q[k-1].dvd[W-1]};
      st_d[k].dvd = {st_q[k-1].dvd[W-2:0], 1'b0};
      if (trial >= {1'b0, st_q[k-1].mb}) begin
        st_d[k].rem = W'(trial - {1'b0, st_q[k-1].mb});
        st_d[k].quo = {st_q[k-1].quo[W-2:0], 1'b1};
      end else begin
        st_d[k].rem = trial[W-1:0];
        st_d[k].quo = {st_q[k-1].quo[W-2:0], 1'b0};
      end
      if (k == 1 && st_q[0].op == OP_MUL) begin
        st_d[k].res = W'(pp_ll_q) + (W'(pp_lh_q + pp_hl_q) << HW);
      end
    end
  end

  always_comb begin
    case (st_q[W].op)
      OP_DIV: begin
        if (st_q[W].bz) begin
          res_d = '0;
        end else if (st_q[W].na != st_q[W].nb) begin
          res_d = ~st_q[W].quo + W'(1);
        end else begin
          res_d = st_q[W].quo;
        end
      end
      OP_MOD: begin
        if (st_q[W].bz) begin
          res_d = st_q[W].a;
        end else if (st_q[W].na) begin
          res_d = ~st_q[W].rem + W'(1);
        end else begin
          res_d = st_q[W].rem;
        end
      end
      default: res_d = st_q[W].res;
    endcase
    if (!st_q[W].ok) begin
      res_d = '0;
    end
    crash_d = !st_q[W].ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[W-1:0], in_i.valid};
      out_v_q <= v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= W; k++) begin
        st_q[k] <= st_d[k];
      end
      pp_ll_q <= pp_ll_d;
      pp_lh_q <= pp_lh_d;
      pp_hl_q <= pp_hl_d;
      res_q   <= res_d;
      crash_q <= crash_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.result_value = res_q;
  assign out_o.crashed      = crash_q;

endmodule

### rtl/vsa_checker.sv
// Port-level checker for the scalar ALU, bound to the top level.
`include "vm_scalar_alu_32_assert.svh"

module vsa_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [DATA_WIDTH-1:0] result_value_i,
  input logic                  crashed_i
);

  `VSA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "word dropped while stalled")
  `VSA_ASSERT(a_crash_zero, clk_i, rst_ni, out_valid_i && crashed_i |-> result_value_i == '0, "crash word with nonzero result")
  `VSA_ASSERT(a_ready_rule, clk_i, rst_ni, in_ready_i == (!out_valid_i || out_ready_i), "input ready out of step with output stall")
  `VSA_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_i, "output valid during reset")

endmodule

bind vm_scalar_alu_32 vsa_checker #(.DATA_WIDTH(DATA_WIDTH)) u_vsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_value_i (out_o.result_value),
  .crashed_i      (out_o.crashed)
);
